>>> hdl/vfcm_pkg.sv
`default_nettype none

package vfcm_pkg;

    // Field widths
    localparam int COORD_W    = 4;
    localparam int SIDE_W     = 3;
    localparam int CMD_W      = 2;
    localparam int POS_W      = 32;
    localparam int EDGE_W     = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int NUM_SIDES  = 6;
    localparam int CORNER_W   = 3;

    // Commands
    localparam logic [CMD_W-1:0] CMD_LOAD_OWN = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_NBR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PROCESS  = 2'd2;

    // Side / face codes
    localparam logic [SIDE_W-1:0] SIDE_NEG_X = 3'd0;
    localparam logic [SIDE_W-1:0] SIDE_POS_X = 3'd1;
    localparam logic [SIDE_W-1:0] SIDE_NEG_Y = 3'd2;
    localparam logic [SIDE_W-1:0] SIDE_POS_Y = 3'd3;
    localparam logic [SIDE_W-1:0] SIDE_NEG_Z = 3'd4;
    localparam logic [SIDE_W-1:0] SIDE_POS_Z = 3'd5;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_EDGE = 2'd3;

    localparam logic [EDGE_W-1:0] EDGE_RESET = 25'd256;

    // Corner code bits: +x, +z, +y
    localparam int CORNER_PX = 0;
    localparam int CORNER_PZ = 1;
    localparam int CORNER_PY = 2;

    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;

    // Six corners per face, two triangles
    localparam logic [CORNER_W-1:0] FACE_CORNERS [0:5][0:5] = '{
        '{3'd0, 3'd2, 3'd4, 3'd4, 3'd2, 3'd6},
        '{3'd3, 3'd1, 3'd7, 3'd7, 3'd1, 3'd5},
        '{3'd0, 3'd1, 3'd2, 3'd2, 3'd1, 3'd3},
        '{3'd6, 3'd7, 3'd4, 3'd4, 3'd7, 3'd5},
        '{3'd1, 3'd0, 3'd5, 3'd5, 3'd0, 3'd4},
        '{3'd3, 3'd7, 3'd2, 3'd2, 3'd7, 3'd6}
    };

    typedef struct packed {
        logic                clear_valid;
        logic                lookup_valid;
        logic                lookup_own;
        logic [SIDE_W-1:0]   lookup_face;
        logic                emit_valid;
        logic [SIDE_W-1:0]   emit_face;
        logic [CORNER_W-1:0] emit_corner;
        logic                emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic                 in_range;
        logic                 own_filled;
        logic [NUM_SIDES-1:0] exposed;
    } dp_status_t;

endpackage

`default_nettype wire

>>> hdl/vfcm_datapath.sv
`default_nettype none

module vfcm_datapath #(
    parameter int GRID_SIZE = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              accept,
    input  wire logic [vfcm_pkg::CMD_W-1:0]        command,
    input  wire logic [vfcm_pkg::COORD_W-1:0]      cell_x,
    input  wire logic [vfcm_pkg::COORD_W-1:0]      cell_y,
    input  wire logic [vfcm_pkg::COORD_W-1:0]      cell_z,
    input  wire logic [vfcm_pkg::SIDE_W-1:0]       neighbor_side,
    input  wire logic                              filled,
    input  wire logic                              cfg_valid,
    input  wire logic [vfcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vfcm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire vfcm_pkg::ctrl_cmd_t               cmd,
    input  wire logic [$clog2((GRID_SIZE*GRID_SIZE > 6*GRID_SIZE) ?
                              GRID_SIZE*GRID_SIZE : 6*GRID_SIZE)-1:0] clear_row,
    output vfcm_pkg::dp_status_t                   sts,
    output logic                                   result_valid,
    output logic signed [vfcm_pkg::POS_W-1:0]      vertex_x,
    output logic signed [vfcm_pkg::POS_W-1:0]      vertex_y,
    output logic signed [vfcm_pkg::POS_W-1:0]      vertex_z,
    output logic [vfcm_pkg::SIDE_W-1:0]            face_side,
    output logic                                   last
);

    localparam int CW       = $clog2(GRID_SIZE);
    localparam int ROWS_OWN = GRID_SIZE * GRID_SIZE;
    localparam int ROWS_PLN = vfcm_pkg::NUM_SIDES * GRID_SIZE;
    localparam int OAW      = $clog2(ROWS_OWN);
    localparam int PAW      = $clog2(ROWS_PLN);
    localparam int CLR_ROWS = (ROWS_OWN > ROWS_PLN) ? ROWS_OWN : ROWS_PLN;
    localparam int CLW      = $clog2(CLR_ROWS);
    localparam logic [CW-1:0] TOP = CW'(GRID_SIZE - 1);

    localparam int PW = vfcm_pkg::POS_W;

    function automatic logic [OAW-1:0] own_row(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return OAW'(int'(a) * GRID_SIZE + int'(b));
    endfunction

    function automatic logic [PAW-1:0] pln_row(input logic [vfcm_pkg::SIDE_W-1:0] side,
                                               input logic [CW-1:0] a);
        return PAW'(int'(side) * GRID_SIZE + int'(a));
    endfunction

    // Occupancy: own grid as rows over z, neighbor planes as rows over the second tangent
    logic [GRID_SIZE-1:0] own_mem [ROWS_OWN];
    logic [GRID_SIZE-1:0] pln_mem [ROWS_PLN];

    logic [CW-1:0] xi, yi, zi;
    logic          in_range;

    logic          own_we;
    logic [OAW-1:0] own_waddr;
    logic          pln_we;
    logic [PAW-1:0] pln_waddr;
    logic [CW-1:0] pln_wbit;

    logic [PW-1:0]            origin_x_reg, origin_y_reg, origin_z_reg;
    logic [vfcm_pkg::EDGE_W-1:0] edge_reg;

    logic [CW-1:0] x_reg, y_reg, z_reg;

    logic [OAW-1:0] own_raddr;
    logic [PAW-1:0] pln_raddr;
    logic [CW-1:0]  rd_bit;
    logic           use_plane;

    logic [GRID_SIZE-1:0] own_rd_reg, pln_rd_reg;
    logic                 cap_valid_reg, cap_own_reg, cap_plane_reg;
    logic [vfcm_pkg::SIDE_W-1:0] cap_face_reg;
    logic [CW-1:0]        cap_bit_reg;
    logic                 cap_solid;

    logic                 own_filled_reg;
    logic [vfcm_pkg::NUM_SIDES-1:0] exposed_reg;

    logic [PW-1:0] half;
    logic [PW-1:0] cx_reg, cy_reg, cz_reg;
    logic [PW-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg, z_lo_reg, z_hi_reg;

    logic [vfcm_pkg::CORNER_W-1:0] corner;
    logic                          result_valid_reg;
    logic [PW-1:0]                 vx_reg, vy_reg, vz_reg;
    logic [vfcm_pkg::SIDE_W-1:0]   face_reg;
    logic                          last_reg;

    assign xi = CW'(cell_x);
    assign yi = CW'(cell_y);
    assign zi = CW'(cell_z);
    assign in_range = (int'(cell_x) < GRID_SIZE) && (int'(cell_y) < GRID_SIZE) &&
                      (int'(cell_z) < GRID_SIZE);

    // Load decode
    assign own_we    = accept && (command == vfcm_pkg::CMD_LOAD_OWN) && in_range;
    assign own_waddr = own_row(xi, yi);

    always_comb
    begin
        pln_we    = 1'b0;
        pln_waddr = pln_row(neighbor_side, yi);
        pln_wbit  = zi;
        case (neighbor_side)
            vfcm_pkg::SIDE_NEG_X:
            begin
                pln_we = (xi == TOP);
            end
            vfcm_pkg::SIDE_POS_X:
            begin
                pln_we = (xi == '0);
            end
            vfcm_pkg::SIDE_NEG_Y:
            begin
                pln_we    = (yi == TOP);
                pln_waddr = pln_row(neighbor_side, xi);
            end
            vfcm_pkg::SIDE_POS_Y:
            begin
                pln_we    = (yi == '0);
                pln_waddr = pln_row(neighbor_side, xi);
            end
            vfcm_pkg::SIDE_NEG_Z:
            begin
                pln_we    = (zi == TOP);
                pln_waddr = pln_row(neighbor_side, xi);
                pln_wbit  = yi;
            end
            vfcm_pkg::SIDE_POS_Z:
            begin
                pln_we    = (zi == '0);
                pln_waddr = pln_row(neighbor_side, xi);
                pln_wbit  = yi;
            end
            default:
            begin
                pln_we = 1'b0;
            end
        endcase
        pln_we = pln_we && accept && (command == vfcm_pkg::CMD_LOAD_NBR) && in_range;
    end

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
            edge_reg     <= vfcm_pkg::EDGE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                vfcm_pkg::CFG_ORIGIN_X:  origin_x_reg <= cfg_data;
                vfcm_pkg::CFG_ORIGIN_Y:  origin_y_reg <= cfg_data;
                vfcm_pkg::CFG_ORIGIN_Z:  origin_z_reg <= cfg_data;
                vfcm_pkg::CFG_CELL_EDGE: edge_reg <= cfg_data[vfcm_pkg::EDGE_W-1:0];
                default:                 edge_reg <= edge_reg;
            endcase
        end
    end

    // Neighbor lookup address: own cell, then one face per step
    always_comb
    begin
        own_raddr = own_row(x_reg, y_reg);
        pln_raddr = pln_row(cmd.lookup_face, y_reg);
        rd_bit    = z_reg;
        use_plane = 1'b0;
        if (!cmd.lookup_own)
        begin
            case (cmd.lookup_face)
                vfcm_pkg::SIDE_NEG_X:
                begin
                    use_plane = (x_reg == '0);
                    own_raddr = own_row(x_reg - 1'b1, y_reg);
                end
                vfcm_pkg::SIDE_POS_X:
                begin
                    use_plane = (x_reg == TOP);
                    own_raddr = own_row(x_reg + 1'b1, y_reg);
                end
                vfcm_pkg::SIDE_NEG_Y:
                begin
                    use_plane = (y_reg == '0);
                    own_raddr = own_row(x_reg, y_reg - 1'b1);
                    pln_raddr = pln_row(cmd.lookup_face, x_reg);
                end
                vfcm_pkg::SIDE_POS_Y:
                begin
                    use_plane = (y_reg == TOP);
                    own_raddr = own_row(x_reg, y_reg + 1'b1);
                    pln_raddr = pln_row(cmd.lookup_face, x_reg);
                end
                vfcm_pkg::SIDE_NEG_Z:
                begin
                    use_plane = (z_reg == '0);
                    rd_bit    = use_plane ? y_reg : z_reg - 1'b1;
                    pln_raddr = pln_row(cmd.lookup_face, x_reg);
                end
                vfcm_pkg::SIDE_POS_Z:
                begin
                    use_plane = (z_reg == TOP);
                    rd_bit    = use_plane ? y_reg : z_reg + 1'b1;
                    pln_raddr = pln_row(cmd.lookup_face, x_reg);
                end
                default:
                begin
                    use_plane = 1'b0;
                end
            endcase
        end
    end

    // Memories: clear sweep, bit writes, registered row reads
    always_ff @(posedge clk)
    begin
        if (cmd.clear_valid && (int'(clear_row) < ROWS_OWN))
            own_mem[OAW'(clear_row)] <= '0;
        else if (own_we)
            own_mem[own_waddr][zi] <= filled;
        own_rd_reg <= own_mem[own_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_valid && (int'(clear_row) < ROWS_PLN))
            pln_mem[PAW'(clear_row)] <= '0;
        else if (pln_we)
            pln_mem[pln_waddr][pln_wbit] <= filled;
        pln_rd_reg <= pln_mem[pln_raddr];
    end

    assign cap_solid = cap_plane_reg ? pln_rd_reg[cap_bit_reg] : own_rd_reg[cap_bit_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_valid_reg <= 1'b0;
        else
            cap_valid_reg <= cmd.lookup_valid;
    end

    always_ff @(posedge clk)
    begin
        cap_own_reg   <= cmd.lookup_own;
        cap_face_reg  <= cmd.lookup_face;
        cap_plane_reg <= use_plane;
        cap_bit_reg   <= rd_bit;
        if (cap_valid_reg)
        begin
            if (cap_own_reg)
                own_filled_reg <= cap_solid;
            else
                exposed_reg[cap_face_reg] <= !cap_solid;
        end
    end

    // Geometry: center then corner bounds, settled well before emission
    assign half = PW'(edge_reg[vfcm_pkg::EDGE_W-1:1]);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= xi;
            y_reg <= yi;
            z_reg <= zi;
        end
        cx_reg   <= origin_x_reg + PW'(PW'(x_reg) * PW'(edge_reg));
        cy_reg   <= origin_y_reg + PW'(PW'(y_reg) * PW'(edge_reg));
        cz_reg   <= origin_z_reg + PW'(PW'(z_reg) * PW'(edge_reg));
        x_lo_reg <= cx_reg - half;
        x_hi_reg <= cx_reg + half;
        y_lo_reg <= cy_reg - half;
        y_hi_reg <= cy_reg + half;
        z_lo_reg <= cz_reg - half;
        z_hi_reg <= cz_reg + half;
    end

    // Vertex output register
    assign corner = vfcm_pkg::FACE_CORNERS[cmd.emit_face][cmd.emit_corner];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= cmd.emit_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_valid)
        begin
            vx_reg   <= corner[vfcm_pkg::CORNER_PX] ? x_hi_reg : x_lo_reg;
            vy_reg   <= corner[vfcm_pkg::CORNER_PY] ? y_hi_reg : y_lo_reg;
            vz_reg   <= corner[vfcm_pkg::CORNER_PZ] ? z_hi_reg : z_lo_reg;
            face_reg <= cmd.emit_face;
            last_reg <= cmd.emit_last;
        end
    end

    assign sts.in_range   = in_range;
    assign sts.own_filled = own_filled_reg;
    assign sts.exposed    = exposed_reg;

    assign result_valid = result_valid_reg;
    assign vertex_x     = signed'(vx_reg);
    assign vertex_y     = signed'(vy_reg);
    assign vertex_z     = signed'(vz_reg);
    assign face_side    = face_reg;
    assign last         = last_reg;

    // A cell's final vertex is never directly followed by another
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && last_reg |=> !result_valid_reg)
        else $error("vertex strobe right after final vertex");

    // Loads never land while the clearing sweep runs
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !cmd.clear_valid)
        else $error("item accepted during clear sweep");

endmodule

`default_nettype wire

>>> hdl/vfcm_ctrl.sv
`default_nettype none

module vfcm_ctrl #(
    parameter int GRID_SIZE = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic [vfcm_pkg::CMD_W-1:0]   command,
    input  wire vfcm_pkg::dp_status_t         sts,
    output vfcm_pkg::ctrl_cmd_t               cmd,
    output logic [$clog2((GRID_SIZE*GRID_SIZE > 6*GRID_SIZE) ?
                         GRID_SIZE*GRID_SIZE : 6*GRID_SIZE)-1:0] clear_row,
    output logic                              busy
);

    localparam int ROWS_OWN = GRID_SIZE * GRID_SIZE;
    localparam int ROWS_PLN = vfcm_pkg::NUM_SIDES * GRID_SIZE;
    localparam int CLR_ROWS = (ROWS_OWN > ROWS_PLN) ? ROWS_OWN : ROWS_PLN;
    localparam int CLW      = $clog2(CLR_ROWS);
    localparam logic [CLW-1:0] CLR_LAST = CLW'(CLR_ROWS - 1);

    // Step 0 reads the cell itself, steps 1..6 the faces, step 7 drains the read
    localparam logic [2:0] LOOKUP_ISSUE_END = 3'd6;
    localparam logic [2:0] LOOKUP_END       = 3'd7;

    localparam int NS = vfcm_pkg::NUM_SIDES;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    function automatic logic [vfcm_pkg::SIDE_W-1:0] lowest_set(input logic [NS-1:0] v);
        logic [vfcm_pkg::SIDE_W-1:0] idx;
        idx = '0;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (v[i])
                idx = vfcm_pkg::SIDE_W'(i);
        end
        return idx;
    endfunction

    state_t                          state_reg, state_next;
    logic                            busy_reg, busy_next;
    logic [CLW-1:0]                  clr_reg, clr_next;
    logic [2:0]                      step_reg, step_next;
    logic [vfcm_pkg::SIDE_W-1:0]     face_reg, face_next;
    logic [vfcm_pkg::CORNER_W-1:0]   corner_reg, corner_next;

    logic [NS-1:0]                   above;
    logic [NS-1:0]                   remaining;
    logic                            more_faces;

    always_comb
    begin
        for (int i = 0; i < NS; i++)
            above[i] = (vfcm_pkg::SIDE_W'(i) > face_reg);
    end

    assign remaining  = sts.exposed & above;
    assign more_faces = |remaining;

    always_comb
    begin
        cmd.clear_valid  = (state_reg == ST_CLEAR);
        cmd.lookup_valid = (state_reg == ST_LOOKUP) && (step_reg <= LOOKUP_ISSUE_END);
        cmd.lookup_own   = (step_reg == '0);
        cmd.lookup_face  = step_reg - 3'd1;
        cmd.emit_valid   = (state_reg == ST_EMIT);
        cmd.emit_face    = face_reg;
        cmd.emit_corner  = corner_reg;
        cmd.emit_last    = (corner_reg == vfcm_pkg::LAST_CORNER) && !more_faces;
    end

    always_comb
    begin
        state_next  = state_reg;
        busy_next   = busy_reg;
        clr_next    = clr_reg;
        step_next   = step_reg;
        face_next   = face_reg;
        corner_next = corner_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (accept && (command == vfcm_pkg::CMD_PROCESS) && sts.in_range)
                begin
                    state_next = ST_LOOKUP;
                    busy_next  = 1'b1;
                    step_next  = '0;
                end
            end
            ST_LOOKUP:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == LOOKUP_END)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (sts.own_filled && (|sts.exposed))
                begin
                    state_next  = ST_EMIT;
                    face_next   = lowest_set(sts.exposed);
                    corner_next = '0;
                end
                else
                begin
                    state_next = ST_IDLE;
                    busy_next  = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (corner_reg == vfcm_pkg::LAST_CORNER)
                begin
                    corner_next = '0;
                    if (more_faces)
                        face_next = lowest_set(remaining);
                    else
                    begin
                        state_next = ST_IDLE;
                        busy_next  = 1'b0;
                    end
                end
                else
                    corner_next = corner_reg + 1'b1;
            end
            default:
            begin
                state_next = ST_IDLE;
                busy_next  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            busy_reg   <= 1'b1;
            clr_reg    <= '0;
            step_reg   <= '0;
            face_reg   <= '0;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            busy_reg   <= busy_next;
            clr_reg    <= clr_next;
            step_reg   <= step_next;
            face_reg   <= face_next;
            corner_reg <= corner_next;
        end
    end

    assign clear_row = clr_reg;
    assign busy      = busy_reg;

    // Only faces found open are ever emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_valid |-> sts.exposed[cmd.emit_face])
        else $error("emitting a covered face");

    // Final vertex of a cell releases the block
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_valid && cmd.emit_last |=> !busy_reg)
        else $error("busy held after final vertex");

    // Clear, lookup and emission never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_valid, cmd.lookup_valid, cmd.emit_valid}))
        else $error("overlapping datapath commands");

    // Datapath work only while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lookup_valid || cmd.emit_valid || cmd.clear_valid) |-> busy_reg)
        else $error("datapath command while idle");

endmodule

`default_nettype wire

>>> hdl/voxel_face_culling_mesher_core.sv
`default_nettype none

// Voxel face-culling mesher. Holds the occupancy grid of one chunk plus the
// touching boundary plane of each of its six neighbor chunks; a neighbor never
// loaded reads as empty. Items are commands taken on start while busy is low.
// Loads (own cell, neighbor boundary cell) are written at the accept edge and
// never raise busy, so loads can be issued every cycle while busy is low. A
// process command with an in-range cell raises busy through neighbor lookup
// (the cell itself, then its six faces, then a drain step), one read per cycle
// through the single read port of each occupancy memory, a decision state and,
// for a filled cell, one vertex per cycle for each open face. Vertices appear
// on result_valid in the cycle after the controller issues them, each for
// exactly one cycle; the receiver cannot stall, so it must take every beat.
// last marks the final vertex of a cell. A cell that is empty or fully
// enclosed, or a command with a coordinate outside the grid, gives no beats.
// After reset a clearing pass sweeps every row of both memories with busy
// high; configuration writes are taken at all times and should be made only
// while busy is low and no beat is pending.

module voxel_face_culling_mesher_core #(
    parameter int GRID_SIZE = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // command channel
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [vfcm_pkg::CMD_W-1:0]        command,
    input  wire logic [vfcm_pkg::COORD_W-1:0]      cell_x,
    input  wire logic [vfcm_pkg::COORD_W-1:0]      cell_y,
    input  wire logic [vfcm_pkg::COORD_W-1:0]      cell_z,
    input  wire logic [vfcm_pkg::SIDE_W-1:0]       neighbor_side,
    input  wire logic                              filled,
    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [vfcm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [vfcm_pkg::CFG_DATA_W-1:0]   cfg_data,
    // vertex results
    output logic                                   result_valid,
    output logic signed [vfcm_pkg::POS_W-1:0]      vertex_x,
    output logic signed [vfcm_pkg::POS_W-1:0]      vertex_y,
    output logic signed [vfcm_pkg::POS_W-1:0]      vertex_z,
    output logic [vfcm_pkg::SIDE_W-1:0]            face_side,
    output logic                                   last
);

    localparam int ROWS_OWN = GRID_SIZE * GRID_SIZE;
    localparam int ROWS_PLN = vfcm_pkg::NUM_SIDES * GRID_SIZE;
    localparam int CLR_ROWS = (ROWS_OWN > ROWS_PLN) ? ROWS_OWN : ROWS_PLN;
    localparam int CLW      = $clog2(CLR_ROWS);

    vfcm_pkg::ctrl_cmd_t  cmd;
    vfcm_pkg::dp_status_t sts;
    logic [CLW-1:0]       clear_row;
    logic                 busy_int;
    logic                 accept;

    // A command beat lands whenever start meets an idle block
    assign accept    = start && !busy_int;
    assign busy      = busy_int;
    // Config registers are plain flops, always writable
    assign cfg_ready = 1'b1;

    vfcm_ctrl #(
        .GRID_SIZE (GRID_SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .sts       (sts),
        .cmd       (cmd),
        .clear_row (clear_row),
        .busy      (busy_int)
    );

    vfcm_datapath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .command       (command),
        .cell_x        (cell_x),
        .cell_y        (cell_y),
        .cell_z        (cell_z),
        .neighbor_side (neighbor_side),
        .filled        (filled),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .clear_row     (clear_row),
        .sts           (sts),
        .result_valid  (result_valid),
        .vertex_x      (vertex_x),
        .vertex_y      (vertex_y),
        .vertex_z      (vertex_z),
        .face_side     (face_side),
        .last          (last)
    );

endmodule

`default_nettype wire

>>> test/mesh_checker.sv
`default_nettype none

module mesh_checker
    import vfcm_pkg::*;
#(
    parameter int GRID_SIZE = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic                  busy,
    input  wire logic [CMD_W-1:0]      command,
    input  wire logic [COORD_W-1:0]    cell_x,
    input  wire logic [COORD_W-1:0]    cell_y,
    input  wire logic [COORD_W-1:0]    cell_z,
    input  wire logic [SIDE_W-1:0]     neighbor_side,
    input  wire logic                  filled,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  result_valid,
    input  wire logic [POS_W-1:0]      vertex_x,
    input  wire logic [POS_W-1:0]      vertex_y,
    input  wire logic [POS_W-1:0]      vertex_z,
    input  wire logic [SIDE_W-1:0]     face_side,
    input  wire logic                  last,
    output int                         errors,
    output int                         pending,
    output int                         beats
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOP_CELL = GRID_SIZE - 1;
    localparam int SHOWN    = 10;

    typedef struct packed {
        logic [POS_W-1:0]  x;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  z;
        logic [SIDE_W-1:0] side;
        logic              last;
    } vertex_t;

    // corner bits: [0] +x, [1] +z, [2] +y; two triangles per face
    localparam logic [2:0] QUAD_ORDER [NUM_SIDES][6] = '{
        '{3'd0, 3'd2, 3'd4, 3'd4, 3'd2, 3'd6},
        '{3'd3, 3'd1, 3'd7, 3'd7, 3'd1, 3'd5},
        '{3'd0, 3'd1, 3'd2, 3'd2, 3'd1, 3'd3},
        '{3'd6, 3'd7, 3'd4, 3'd4, 3'd7, 3'd5},
        '{3'd1, 3'd0, 3'd5, 3'd5, 3'd0, 3'd4},
        '{3'd3, 3'd7, 3'd2, 3'd2, 3'd7, 3'd6}
    };

    bit                solid [GRID_SIZE][GRID_SIZE][GRID_SIZE];
    bit                plane [NUM_SIDES][GRID_SIZE][GRID_SIZE];
    logic [POS_W-1:0]  org_x;
    logic [POS_W-1:0]  org_y;
    logic [POS_W-1:0]  org_z;
    logic [EDGE_W-1:0] cell_len;
    vertex_t           expected_vertices [$];
    int                mismatches;

    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= SHOWN)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Queue the quads of every open face of a filled cell.
    function automatic void predict_cell_quads(input int x, input int y, input int z);
        logic [POS_W-1:0] half;
        logic [POS_W-1:0] cx;
        logic [POS_W-1:0] cy;
        logic [POS_W-1:0] cz;
        logic [2:0]       c;
        bit               open [NUM_SIDES];
        int               final_face;
        vertex_t          v;
        half = POS_W'(cell_len >> 1);
        cx = org_x + POS_W'(x) * POS_W'(cell_len);
        cy = org_y + POS_W'(y) * POS_W'(cell_len);
        cz = org_z + POS_W'(z) * POS_W'(cell_len);
        final_face = -1;
        for (int f = 0; f < NUM_SIDES; f++) begin
            case (SIDE_W'(f))
                SIDE_NEG_X: open[f] = (x == 0) ? !plane[f][y][z] : !solid[x-1][y][z];
                SIDE_POS_X: open[f] = (x == TOP_CELL) ? !plane[f][y][z] : !solid[x+1][y][z];
                SIDE_NEG_Y: open[f] = (y == 0) ? !plane[f][x][z] : !solid[x][y-1][z];
                SIDE_POS_Y: open[f] = (y == TOP_CELL) ? !plane[f][x][z] : !solid[x][y+1][z];
                SIDE_NEG_Z: open[f] = (z == 0) ? !plane[f][x][y] : !solid[x][y][z-1];
                default:    open[f] = (z == TOP_CELL) ? !plane[f][x][y] : !solid[x][y][z+1];
            endcase
            if (open[f])
                final_face = f;
        end
        for (int f = 0; f < NUM_SIDES; f++) begin
            if (open[f]) begin
                for (int k = 0; k < 6; k++) begin
                    c = QUAD_ORDER[f][k];
                    v.x = c[0] ? cx + half : cx - half;
                    v.y = c[2] ? cy + half : cy - half;
                    v.z = c[1] ? cz + half : cz - half;
                    v.side = SIDE_W'(f);
                    v.last = (f == final_face) && (k == 5);
                    expected_vertices.push_back(v);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        vertex_t want;
        int      x;
        int      y;
        int      z;
        if (!rst_n) begin
            foreach (solid[i, j, k])
                solid[i][j][k] = 1'b0;
            foreach (plane[i, j, k])
                plane[i][j][k] = 1'b0;
            org_x = '0;
            org_y = '0;
            org_z = '0;
            cell_len = EDGE_RESET;
            expected_vertices.delete();
            mismatches = 0;
            errors <= 0;
            pending <= 0;
            beats <= 0;
        end
        else begin
            // results first: a new command may be taken on the edge of an older last beat
            if (result_valid) begin
                beats <= beats + 1;
                if (expected_vertices.size() == 0) begin
                    note_failure($sformatf("unexpected vertex (%0d,%0d,%0d) face %0d last %0b",
                        $signed(vertex_x), $signed(vertex_y), $signed(vertex_z),
                        face_side, last));
                end
                else begin
                    want = expected_vertices.pop_front();
                    if (vertex_x !== want.x || vertex_y !== want.y || vertex_z !== want.z ||
                        face_side !== want.side || last !== want.last)
                        note_failure($sformatf(
                            "vertex mismatch: exp (%0d,%0d,%0d) face %0d last %0b, got (%0d,%0d,%0d) face %0d last %0b",
                            $signed(want.x), $signed(want.y), $signed(want.z), want.side,
                            want.last, $signed(vertex_x), $signed(vertex_y), $signed(vertex_z),
                            face_side, last));
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_ORIGIN_X:  org_x = cfg_data;
                    CFG_ORIGIN_Y:  org_y = cfg_data;
                    CFG_ORIGIN_Z:  org_z = cfg_data;
                    CFG_CELL_EDGE: cell_len = cfg_data[EDGE_W-1:0];
                    default: ;
                endcase
            end

            if (start && !busy) begin
                x = cell_x;
                y = cell_y;
                z = cell_z;
                if (x <= TOP_CELL && y <= TOP_CELL && z <= TOP_CELL) begin
                    case (command)
                        CMD_LOAD_OWN: solid[x][y][z] = filled;
                        CMD_LOAD_NBR: begin
                            // only the plane touching this chunk is kept
                            case (neighbor_side)
                                SIDE_NEG_X: if (x == TOP_CELL) plane[SIDE_NEG_X][y][z] = filled;
                                SIDE_POS_X: if (x == 0) plane[SIDE_POS_X][y][z] = filled;
                                SIDE_NEG_Y: if (y == TOP_CELL) plane[SIDE_NEG_Y][x][z] = filled;
                                SIDE_POS_Y: if (y == 0) plane[SIDE_POS_Y][x][z] = filled;
                                SIDE_NEG_Z: if (z == TOP_CELL) plane[SIDE_NEG_Z][x][y] = filled;
                                SIDE_POS_Z: if (z == 0) plane[SIDE_POS_Z][x][y] = filled;
                                default: ;
                            endcase
                        end
                        CMD_PROCESS: if (solid[x][y][z]) predict_cell_quads(x, y, z);
                        default: ;
                    endcase
                end
            end

            errors <= mismatches;
            pending <= expected_vertices.size();
        end
    end

endmodule

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import vfcm_pkg::*;

    localparam int GRID_SIZE   = 16;
    localparam int TOP_CELL    = GRID_SIZE - 1;
    // command code the block must treat as a no-op
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    // margin for the longest busy stretch without a beat (lookup and decision), plus the output stage
    localparam int DRAIN       = 16;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int BLOCKS      = 5;
    localparam int BLOCK_ITEMS = 32;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] = '{
        CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z, CFG_CELL_EDGE
    };

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [CMD_W-1:0]      command;
    logic [COORD_W-1:0]    cell_x;
    logic [COORD_W-1:0]    cell_y;
    logic [COORD_W-1:0]    cell_z;
    logic [SIDE_W-1:0]     neighbor_side;
    logic                  filled;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  result_valid;
    logic [POS_W-1:0]      vertex_x;
    logic [POS_W-1:0]      vertex_y;
    logic [POS_W-1:0]      vertex_z;
    logic [SIDE_W-1:0]     face_side;
    logic                  last;

    int errors;
    int pending;
    int beats;
    int cycles;
    int sent;
    int directed_sent;
    int cfg_writes;
    bit burst;
    // recently filled own cells, {x, y, z}; process commands lean on these
    logic [3*COORD_W-1:0] solid_cells [$];

    voxel_face_culling_mesher_core #(
        .GRID_SIZE(GRID_SIZE)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .neighbor_side(neighbor_side),
        .filled       (filled),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_z     (vertex_z),
        .face_side    (face_side),
        .last         (last)
    );

    // Watches command, config and vertex beats; predicts and compares.
    mesh_checker #(
        .GRID_SIZE(GRID_SIZE)
    ) u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .command      (command),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .neighbor_side(neighbor_side),
        .filled       (filled),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .vertex_x     (vertex_x),
        .vertex_y     (vertex_y),
        .vertex_z     (vertex_z),
        .face_side    (face_side),
        .last         (last),
        .errors       (errors),
        .pending      (pending),
        .beats        (beats)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case a handshake never completes or beats never drain.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d vertices still expected",
                cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Coordinates cluster at the chunk faces so neighbors interact often.
    function automatic logic [COORD_W-1:0] pick_coord();
        logic [COORD_W-1:0] near_face [4] = '{
            COORD_W'(0), COORD_W'(1), COORD_W'(TOP_CELL - 1), COORD_W'(TOP_CELL)
        };
        if ($urandom_range(0, 3) == 0)
            return COORD_W'($urandom_range(0, TOP_CELL));
        return near_face[$urandom_range(0, 3)];
    endfunction

    // One command beat. Start stays high across back-to-back beats;
    // acceptance is start high with busy low at the edge.
    task automatic issue(
        input logic [CMD_W-1:0]   cmd,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z,
        input logic [SIDE_W-1:0]  side,
        input logic               fill
    );
        int gap;
        gap = burst ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        cell_x <= x;
        cell_y <= y;
        cell_z <= z;
        neighbor_side <= side;
        filled <= fill;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent++;
    endtask

    // Block idle: no vertex outstanding, busy low, then a margin for
    // a cell that finished without output.
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic load_config(
        input logic [CFG_DATA_W-1:0] ox,
        input logic [CFG_DATA_W-1:0] oy,
        input logic [CFG_DATA_W-1:0] oz,
        input logic [CFG_DATA_W-1:0] cell_edge
    );
        logic [CFG_DATA_W-1:0] vals [4];
        vals = '{ox, oy, oz, cell_edge};
        settle();
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            cfg_writes++;
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CMD_W-1:0]     cmd;
        logic [COORD_W-1:0]   px;
        logic [COORD_W-1:0]   py;
        logic [COORD_W-1:0]   pz;
        logic [SIDE_W-1:0]    side;
        logic                 fill;
        logic [3*COORD_W-1:0] pick;
        bit                   useful;
        int                   done;

        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_LOAD_OWN;
        cell_x = '0;
        cell_y = '0;
        cell_z = '0;
        neighbor_side = SIDE_NEG_X;
        filled = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ORIGIN_X;
        cfg_data = '0;
        cycles = 0;
        sent = 0;
        cfg_writes = 0;
        burst = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed cases, reset configuration ----
        // empty cell: nothing comes out
        issue(CMD_PROCESS, 0, 0, 0, SIDE_NEG_X, 1'b1);
        // lone cell at the origin corner: all six faces open
        issue(CMD_LOAD_OWN, 0, 0, 0, SIDE_NEG_X, 1'b1);
        issue(CMD_PROCESS, 0, 0, 0, SIDE_NEG_X, 1'b0);
        // close its three low faces through the neighbor planes
        issue(CMD_LOAD_NBR, TOP_CELL, 0, 0, SIDE_NEG_X, 1'b1);
        issue(CMD_LOAD_NBR, 0, TOP_CELL, 0, SIDE_NEG_Y, 1'b1);
        issue(CMD_LOAD_NBR, 0, 0, TOP_CELL, SIDE_NEG_Z, 1'b1);
        // neighbor load off the boundary would reopen -x if it were stored
        issue(CMD_LOAD_NBR, 3, 0, 0, SIDE_NEG_X, 1'b0);
        // unknown neighbor sides do nothing
        issue(CMD_LOAD_NBR, TOP_CELL, 0, 0, 3'd6, 1'b0);
        issue(CMD_LOAD_NBR, TOP_CELL, 0, 0, 3'd7, 1'b0);
        issue(CMD_PROCESS, 0, 0, 0, SIDE_POS_Z, 1'b0);
        // far corner cell, its high faces closed from the other side
        issue(CMD_LOAD_OWN, TOP_CELL, TOP_CELL, TOP_CELL, SIDE_POS_Z, 1'b1);
        issue(CMD_LOAD_NBR, 0, TOP_CELL, TOP_CELL, SIDE_POS_X, 1'b1);
        issue(CMD_LOAD_NBR, TOP_CELL, 0, TOP_CELL, SIDE_POS_Y, 1'b1);
        issue(CMD_LOAD_NBR, TOP_CELL, TOP_CELL, 0, SIDE_POS_Z, 1'b1);
        issue(CMD_PROCESS, TOP_CELL, TOP_CELL, TOP_CELL, 3'd7, 1'b1);
        // unknown command on a filled cell
        issue(CMD_NOP, TOP_CELL, TOP_CELL, TOP_CELL, SIDE_POS_Z, 1'b1);
        // fully enclosed cell: busy but no beats
        issue(CMD_LOAD_OWN, 1, 0, 0, SIDE_NEG_X, 1'b1);
        issue(CMD_LOAD_OWN, 0, 1, 0, SIDE_NEG_X, 1'b1);
        issue(CMD_LOAD_OWN, 0, 0, 1, SIDE_NEG_X, 1'b1);
        issue(CMD_PROCESS, 0, 0, 0, SIDE_NEG_X, 1'b0);
        // empty the origin cell again; its neighbor now sees an open -x face
        issue(CMD_LOAD_OWN, 0, 0, 0, SIDE_NEG_X, 1'b0);
        issue(CMD_PROCESS, 0, 0, 0, SIDE_NEG_X, 1'b0);
        issue(CMD_PROCESS, 1, 0, 0, SIDE_NEG_X, 1'b0);
        directed_sent = sent;
        solid_cells.push_back({COORD_W'(1), COORD_W'(0), COORD_W'(0)});
        solid_cells.push_back({COORD_W'(TOP_CELL), COORD_W'(TOP_CELL), COORD_W'(TOP_CELL)});

        // ---- random blocks, each under its own register setting ----
        for (int blk = 0; blk < BLOCKS; blk++) begin
            case (blk)
                // top of the signed range with the widest cell: sums wrap
                0: load_config(32'h7FFF_FF00, 32'h7FFF_FFFF, 32'h0000_0000, 32'd16777216);
                // bottom of the range with the narrowest cell
                1: load_config(32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF, 32'd2);
                // odd cell edge: half edge truncates
                2: load_config($urandom, $urandom, $urandom, 32'd255);
                // junk above the edge field must be dropped
                3: load_config($urandom, $urandom, $urandom,
                        {7'($urandom), 25'($urandom_range(2, 16777216))});
                default: load_config($urandom, $urandom, $urandom, $urandom_range(2, 1024));
            endcase

            done = 0;
            while (done < BLOCK_ITEMS) begin
                // alternate stretches of back-to-back beats with gapped ones
                if (sent % 12 == 0)
                    burst = ($urandom_range(0, 2) == 0);
                px = pick_coord();
                py = pick_coord();
                pz = pick_coord();
                side = SIDE_W'($urandom);
                fill = 1'($urandom);
                useful = 1'b1;
                case ($urandom_range(0, 99)) inside
                    [0:39]: begin
                        cmd = CMD_LOAD_OWN;
                        fill = ($urandom_range(0, 9) < 7);
                        if (fill) begin
                            solid_cells.push_back({px, py, pz});
                            if (solid_cells.size() > 24)
                                void'(solid_cells.pop_front());
                        end
                    end
                    [40:59]: begin
                        cmd = CMD_LOAD_NBR;
                        side = ($urandom_range(0, 9) == 0) ? SIDE_W'($urandom_range(6, 7))
                                                           : SIDE_W'($urandom_range(0, 5));
                        fill = ($urandom_range(0, 3) != 0);
                        // mostly aim at the plane that touches this chunk
                        if ($urandom_range(0, 4) != 0) begin
                            case (side)
                                SIDE_NEG_X: px = TOP_CELL;
                                SIDE_POS_X: px = 0;
                                SIDE_NEG_Y: py = TOP_CELL;
                                SIDE_POS_Y: py = 0;
                                SIDE_NEG_Z: pz = TOP_CELL;
                                SIDE_POS_Z: pz = 0;
                                default: ;
                            endcase
                        end
                        case (side)
                            SIDE_NEG_X: useful = (px == TOP_CELL);
                            SIDE_POS_X: useful = (px == 0);
                            SIDE_NEG_Y: useful = (py == TOP_CELL);
                            SIDE_POS_Y: useful = (py == 0);
                            SIDE_NEG_Z: useful = (pz == TOP_CELL);
                            SIDE_POS_Z: useful = (pz == 0);
                            default:    useful = 1'b0;
                        endcase
                    end
                    [60:95]: begin
                        cmd = CMD_PROCESS;
                        if (solid_cells.size() > 0 && $urandom_range(0, 9) < 7) begin
                            pick = solid_cells[$urandom_range(0, solid_cells.size() - 1)];
                            {px, py, pz} = pick;
                        end
                    end
                    default: begin
                        cmd = CMD_NOP;
                        useful = 1'b0;
                    end
                endcase
                issue(cmd, px, py, pz, side, fill);
                if (useful)
                    done++;
            end
        end

        settle();

        $display("Covered %0d commands (%0d directed) and %0d register writes over %0d settings.",
            sent, directed_sent, cfg_writes, BLOCKS + 1);
        $display("Compared %0d vertex beats against predicted quads; %0d mismatches.",
            beats, errors);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
